// ===== src/dtt_pkg.sv =====
package dtt_pkg;

    localparam int ROW_WIDTH  = 16;
    localparam int COL_WIDTH  = 10;
    localparam int BYTE_WIDTH = 8;
    localparam int SEP_WIDTH  = 9;
    localparam int EV_WIDTH   = 3;
    localparam int IDX_WIDTH  = 3;
    localparam int OUT_BITS   = EV_WIDTH + ROW_WIDTH + COL_WIDTH + BYTE_WIDTH;
    localparam int OUT_WIDTH  = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_FIELD   = 2'd1,
        MODE_COMMENT = 2'd2
    } mode_t;

    typedef enum logic [EV_WIDTH-1:0] {
        EV_DATA   = 3'd0,
        EV_FIELD  = 3'd1,
        EV_RECORD = 3'd2,
        EV_CLEAR  = 3'd3,
        EV_NONE   = 3'd4
    } event_t;

    typedef enum logic [IDX_WIDTH-1:0] {
        REG_UNIT_SEP_A    = 3'd0,
        REG_UNIT_SEP_B    = 3'd1,
        REG_RECORD_SEP    = 3'd2,
        REG_GROUP_SEP     = 3'd3,
        REG_FILE_SEP      = 3'd4,
        REG_COMMENT_CHAR  = 3'd5,
        REG_ALLOW_EMPTY_F = 3'd6,
        REG_ALLOW_EMPTY_R = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [SEP_WIDTH-1:0] unit_sep_a;
        logic [SEP_WIDTH-1:0] unit_sep_b;
        logic [SEP_WIDTH-1:0] record_sep;
        logic [SEP_WIDTH-1:0] group_sep;
        logic [SEP_WIDTH-1:0] file_sep;
        logic [SEP_WIDTH-1:0] comment_char;
        logic                 empty_field_en;
        logic                 empty_record_en;
    } cfg_t;

    typedef struct packed {
        logic                  valid;
        logic [BYTE_WIDTH-1:0] text_byte;
    } stage_t;

endpackage

// ===== src/dtt_cfg_regs.sv =====
module dtt_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dtt_pkg::IDX_WIDTH-1:0]  cfg_index,
    input  logic [dtt_pkg::SEP_WIDTH-1:0]  cfg_data,
    output dtt_pkg::cfg_t                  cfg
);

    dtt_pkg::cfg_t cfg_reg;
    dtt_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (dtt_pkg::reg_idx_t'(cfg_index))
                dtt_pkg::REG_UNIT_SEP_A:    cfg_next.unit_sep_a      = cfg_data;
                dtt_pkg::REG_UNIT_SEP_B:    cfg_next.unit_sep_b      = cfg_data;
                dtt_pkg::REG_RECORD_SEP:    cfg_next.record_sep      = cfg_data;
                dtt_pkg::REG_GROUP_SEP:     cfg_next.group_sep       = cfg_data;
                dtt_pkg::REG_FILE_SEP:      cfg_next.file_sep        = cfg_data;
                dtt_pkg::REG_COMMENT_CHAR:  cfg_next.comment_char    = cfg_data;
                dtt_pkg::REG_ALLOW_EMPTY_F: cfg_next.empty_field_en  = cfg_data[0];
                dtt_pkg::REG_ALLOW_EMPTY_R: cfg_next.empty_record_en = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.unit_sep_a      <= 9'd32;
            cfg_reg.unit_sep_b      <= 9'd9;
            cfg_reg.record_sep      <= 9'd10;
            cfg_reg.group_sep       <= 9'd256;
            cfg_reg.file_sep        <= 9'd12;
            cfg_reg.comment_char    <= 9'd35;
            cfg_reg.empty_field_en  <= 1'b0;
            cfg_reg.empty_record_en <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/dtt_input_stage.sv =====
module dtt_input_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dtt_pkg::BYTE_WIDTH-1:0]  s_tdata,
    input  logic                            advance,
    output dtt_pkg::stage_t                 stage
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [dtt_pkg::BYTE_WIDTH-1:0] byte_reg;

    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // hold the byte until the parser takes it
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            byte_reg <= s_tdata;
        end
    end

    assign stage.valid     = valid_reg;
    assign stage.text_byte = byte_reg;

endmodule

// ===== src/dtt_parser.sv =====
module dtt_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dtt_pkg::cfg_t                   cfg,
    input  dtt_pkg::stage_t                 stage,
    output logic                            advance,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dtt_pkg::OUT_WIDTH-1:0]   m_tdata
);

    localparam logic [dtt_pkg::ROW_WIDTH-1:0] ROW_MAX = '1;
    localparam logic [dtt_pkg::COL_WIDTH-1:0] COL_MAX = '1;
    localparam int PAD = dtt_pkg::OUT_WIDTH - dtt_pkg::OUT_BITS;

    dtt_pkg::mode_t                  mode_reg, mode_next;
    logic [dtt_pkg::ROW_WIDTH-1:0]   row_reg, row_next;
    logic [dtt_pkg::COL_WIDTH-1:0]   col_reg, col_next;
    logic                            has_data_reg, has_data_next;

    logic                            out_valid_reg, out_valid_next;
    dtt_pkg::event_t                 out_ev_reg, ev;
    logic [dtt_pkg::ROW_WIDTH-1:0]   out_row_reg;
    logic [dtt_pkg::COL_WIDTH-1:0]   out_col_reg;
    logic [dtt_pkg::BYTE_WIDTH-1:0]  out_byte_reg;

    logic [dtt_pkg::SEP_WIDTH-1:0]   c9;
    logic                            is_unit, is_rec, is_file, is_comment;
    logic                            take;

    assign advance = !out_valid_reg || m_tready;
    assign take    = advance && stage.valid;

    assign c9         = {1'b0, stage.text_byte};
    assign is_unit    = (cfg.unit_sep_a == c9) || (cfg.unit_sep_b == c9);
    assign is_rec     = (cfg.record_sep == c9) || (cfg.group_sep == c9);
    assign is_file    = (cfg.file_sep == c9);
    assign is_comment = (cfg.comment_char == c9);

    always_comb begin
        mode_next     = mode_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        has_data_next = has_data_reg;
        ev            = dtt_pkg::EV_NONE;

        if (is_file) begin
            mode_next     = dtt_pkg::MODE_START;
            row_next      = '0;
            col_next      = '0;
            has_data_next = 1'b0;
            ev            = dtt_pkg::EV_CLEAR;
        end else begin
            case (mode_reg)
                dtt_pkg::MODE_COMMENT: begin
                    if (is_rec) begin
                        if (has_data_reg) begin
                            if (row_reg != ROW_MAX) row_next = row_reg + 1'b1;
                            has_data_next = 1'b0;
                        end
                        col_next  = '0;
                        mode_next = dtt_pkg::MODE_START;
                        ev        = dtt_pkg::EV_RECORD;
                    end
                end
                dtt_pkg::MODE_FIELD: begin
                    if (is_unit) begin
                        if (col_reg != COL_MAX) col_next = col_reg + 1'b1;
                        mode_next = dtt_pkg::MODE_START;
                        ev        = dtt_pkg::EV_FIELD;
                    end else if (is_rec) begin
                        if (row_reg != ROW_MAX) row_next = row_reg + 1'b1;
                        has_data_next = 1'b0;
                        col_next      = '0;
                        mode_next     = dtt_pkg::MODE_START;
                        ev            = dtt_pkg::EV_RECORD;
                    end else begin
                        has_data_next = 1'b1;
                        ev            = dtt_pkg::EV_DATA;
                    end
                end
                default: begin
                    if (is_comment) begin
                        mode_next = dtt_pkg::MODE_COMMENT;
                    end else if (is_rec) begin
                        if ((col_reg != '0) || cfg.empty_record_en) begin
                            if (row_reg != ROW_MAX) row_next = row_reg + 1'b1;
                            has_data_next = 1'b0;
                            ev            = dtt_pkg::EV_RECORD;
                        end
                        col_next = '0;
                    end else if (is_unit) begin
                        if (cfg.empty_field_en) begin
                            if (col_reg != COL_MAX) col_next = col_reg + 1'b1;
                            ev = dtt_pkg::EV_FIELD;
                        end
                    end else begin
                        mode_next     = dtt_pkg::MODE_FIELD;
                        has_data_next = 1'b1;
                        ev            = dtt_pkg::EV_DATA;
                    end
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = stage.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= dtt_pkg::MODE_START;
            row_reg       <= '0;
            col_reg       <= '0;
            has_data_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                mode_reg     <= mode_next;
                row_reg      <= row_next;
                col_reg      <= col_next;
                has_data_reg <= has_data_next;
            end
        end
    end

    // data events report the cell in use, which the step never moves
    always_ff @(posedge aclk) begin
        if (take) begin
            out_ev_reg   <= ev;
            out_row_reg  <= row_next;
            out_col_reg  <= col_next;
            out_byte_reg <= stage.text_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD{1'b0}}, out_byte_reg, out_col_reg, out_row_reg,
                       dtt_pkg::EV_WIDTH'(out_ev_reg)};

endmodule

// ===== src/delimited_table_tokenizer_core.sv =====
// Delimited table tokenizer: splits a byte stream into rows and fields.
// Input channel s_*: one text byte per item in s_tdata[7:0].
// Result channel m_*: one item per input byte, m_tdata from bit 0 up:
//   event (3), row (16), column (10), byte (8), zero padding (3).
// Configuration channel cfg_*: cfg_index selects one of eight registers
//   (separators, comment byte, empty field/record switches), cfg_data
//   carries the value; always ready. Write only while the block is idle.
// An accepted item passes through the input register, then the parse logic
//   into the result register, before it appears on m_tvalid.
// Throughput: one item per cycle while m_tready stays high; the parser
//   updates mode, row and field registers once per accepted item.
// Stall: when m_tready is low the result register holds, the input register
//   fills, and s_tready drops only once both are occupied.
// Reset (aresetn low, synchronous): both stages empty, mode at start of
//   field, indices and row data flag cleared, registers to their defaults.
module delimited_table_tokenizer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // text_byte[7:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dtt_pkg::OUT_WIDTH-1:0]   m_tdata,   // event_res, row, column, out_byte
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dtt_pkg::IDX_WIDTH-1:0]   cfg_index,
    input  logic [dtt_pkg::SEP_WIDTH-1:0]   cfg_data
);

    dtt_pkg::cfg_t   cfg;
    dtt_pkg::stage_t stage;
    logic            advance;

    dtt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dtt_input_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .stage    (stage)
    );

    dtt_parser u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .stage    (stage),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== bench/tb_delimited_table_tokenizer_core.sv =====
module tb_delimited_table_tokenizer_core;

    typedef struct packed {
        dtt_pkg::event_t                ev;
        logic [dtt_pkg::ROW_WIDTH-1:0]  row;
        logic [dtt_pkg::COL_WIDTH-1:0]  col;
        logic [dtt_pkg::BYTE_WIDTH-1:0] text;
    } token_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [dtt_pkg::OUT_WIDTH-1:0]  m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [dtt_pkg::IDX_WIDTH-1:0]  cfg_index = '0;
    logic [dtt_pkg::SEP_WIDTH-1:0]  cfg_data = '0;

    logic [7:0]                     text_queue[$];
    token_t                         expected_tokens[$];
    int                             fail_count = 0;
    bit                             no_idle = 1'b0;

    // tokenizer state and register copy
    dtt_pkg::cfg_t                  tk_cfg;
    dtt_pkg::mode_t                 tk_mode;
    logic [dtt_pkg::ROW_WIDTH-1:0]  tk_row;
    logic [dtt_pkg::COL_WIDTH-1:0]  tk_col;
    logic                           tk_row_data;

    delimited_table_tokenizer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit byte_hits(input logic [dtt_pkg::SEP_WIDTH-1:0] r,
                                     input logic [7:0] c);
        return r == {1'b0, c};
    endfunction

    function automatic void advance_row();
        if (tk_row != '1) tk_row = tk_row + 1'b1;
        tk_row_data = 1'b0;
    endfunction

    function automatic void advance_field();
        if (tk_col != '1) tk_col = tk_col + 1'b1;
    endfunction

    function automatic void queue_byte(input logic [7:0] b);
        text_queue.insert(text_queue.size(), b);
    endfunction

    function automatic token_t tokenize(input logic [7:0] c);
        token_t t;
        bit     unit_hit;
        bit     rec_hit;
        bit     stored;
        unit_hit = byte_hits(tk_cfg.unit_sep_a, c) || byte_hits(tk_cfg.unit_sep_b, c);
        rec_hit  = byte_hits(tk_cfg.record_sep, c) || byte_hits(tk_cfg.group_sep, c);
        stored   = 1'b0;
        t.ev     = dtt_pkg::EV_NONE;
        if (byte_hits(tk_cfg.file_sep, c)) begin
            tk_row      = '0;
            tk_col      = '0;
            tk_row_data = 1'b0;
            tk_mode     = dtt_pkg::MODE_START;
            t.ev        = dtt_pkg::EV_CLEAR;
        end else if (tk_mode == dtt_pkg::MODE_COMMENT) begin
            if (rec_hit) begin
                if (tk_row_data) advance_row();
                tk_col  = '0;
                tk_mode = dtt_pkg::MODE_START;
                t.ev    = dtt_pkg::EV_RECORD;
            end
        end else if (tk_mode == dtt_pkg::MODE_FIELD) begin
            if (unit_hit) begin
                advance_field();
                tk_mode = dtt_pkg::MODE_START;
                t.ev    = dtt_pkg::EV_FIELD;
            end else if (rec_hit) begin
                advance_row();
                tk_col  = '0;
                tk_mode = dtt_pkg::MODE_START;
                t.ev    = dtt_pkg::EV_RECORD;
            end else begin
                stored = 1'b1;
            end
        end else begin
            if (byte_hits(tk_cfg.comment_char, c)) begin
                tk_mode = dtt_pkg::MODE_COMMENT;
            end else if (rec_hit) begin
                if (tk_col != '0 || tk_cfg.empty_record_en) begin
                    advance_row();
                    t.ev = dtt_pkg::EV_RECORD;
                end
                tk_col = '0;
            end else if (unit_hit) begin
                if (tk_cfg.empty_field_en) begin
                    advance_field();
                    t.ev = dtt_pkg::EV_FIELD;
                end
            end else begin
                tk_mode = dtt_pkg::MODE_FIELD;
                stored  = 1'b1;
            end
        end
        if (stored) begin
            tk_row_data = 1'b1;
            t.ev        = dtt_pkg::EV_DATA;
        end
        t.row  = tk_row;
        t.col  = tk_col;
        t.text = c;
        return t;
    endfunction

    // driver: send text bytes, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_tokens.insert(expected_tokens.size(), tokenize(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (text_queue.size() != 0 && (no_idle || $urandom_range(99) >= 14)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= text_queue.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result item with the oldest prediction
    always @(posedge aclk) begin : monitor
        token_t got;
        token_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{ev: dtt_pkg::event_t'(m_tdata[2:0]), row: m_tdata[18:3],
                        col: m_tdata[28:19], text: m_tdata[36:29]};
                if (expected_tokens.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected item ev=%0d row=%0d col=%0d byte=%02h",
                             $time, got.ev, got.row, got.col, got.text);
                end else begin
                    want = expected_tokens.pop_front();
                    if (got.ev !== want.ev || got.row !== want.row ||
                        got.col !== want.col || got.text !== want.text) begin
                        fail_count++;
                        $display("%0t: expected %0d %0d %0d %02h, got %0d %0d %0d %02h",
                                 $time, want.ev, want.row, want.col, want.text,
                                 got.ev, got.row, got.col, got.text);
                    end
                end
            end
            m_tready <= no_idle || $urandom_range(99) >= 14;
        end
    end

    task automatic write_reg(input dtt_pkg::reg_idx_t idx,
                             input logic [dtt_pkg::SEP_WIDTH-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            dtt_pkg::REG_UNIT_SEP_A:    tk_cfg.unit_sep_a = val;
            dtt_pkg::REG_UNIT_SEP_B:    tk_cfg.unit_sep_b = val;
            dtt_pkg::REG_RECORD_SEP:    tk_cfg.record_sep = val;
            dtt_pkg::REG_GROUP_SEP:     tk_cfg.group_sep = val;
            dtt_pkg::REG_FILE_SEP:      tk_cfg.file_sep = val;
            dtt_pkg::REG_COMMENT_CHAR:  tk_cfg.comment_char = val;
            dtt_pkg::REG_ALLOW_EMPTY_F: tk_cfg.empty_field_en = val[0];
            dtt_pkg::REG_ALLOW_EMPTY_R: tk_cfg.empty_record_en = val[0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [8:0] ua, input logic [8:0] ub,
                                input logic [8:0] rs, input logic [8:0] gs,
                                input logic [8:0] fs, input logic [8:0] cc,
                                input logic [8:0] aef, input logic [8:0] aer);
        write_reg(dtt_pkg::REG_UNIT_SEP_A, ua);
        write_reg(dtt_pkg::REG_UNIT_SEP_B, ub);
        write_reg(dtt_pkg::REG_RECORD_SEP, rs);
        write_reg(dtt_pkg::REG_GROUP_SEP, gs);
        write_reg(dtt_pkg::REG_FILE_SEP, fs);
        write_reg(dtt_pkg::REG_COMMENT_CHAR, cc);
        write_reg(dtt_pkg::REG_ALLOW_EMPTY_F, aef);
        write_reg(dtt_pkg::REG_ALLOW_EMPTY_R, aer);
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (text_queue.size() != 0 || s_tvalid || expected_tokens.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [7:0] byte_or_any(input logic [dtt_pkg::SEP_WIDTH-1:0] r);
        return r[8] ? 8'($urandom_range(255)) : r[7:0];
    endfunction

    function automatic logic [7:0] plain_byte();
        return ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                        : 8'($urandom_range(33, 126));
    endfunction

    function automatic logic [7:0] unit_byte();
        return $urandom_range(1) ? byte_or_any(tk_cfg.unit_sep_a)
                                 : byte_or_any(tk_cfg.unit_sep_b);
    endfunction

    function automatic logic [7:0] end_byte();
        return $urandom_range(3) != 0 ? byte_or_any(tk_cfg.record_sep)
                                      : byte_or_any(tk_cfg.group_sep);
    endfunction

    // mostly well-formed rows and comment lines, with some noise and clears
    task automatic queue_text(input int n);
        int made;
        int nf;
        int len;
        int pick;
        int f;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                queue_byte(8'($urandom_range(255)));
                made++;
            end else if (pick < 15) begin
                queue_byte(byte_or_any(tk_cfg.file_sep));
                made++;
            end else if (pick < 27) begin
                queue_byte(byte_or_any(tk_cfg.comment_char));
                len = $urandom_range(4);
                repeat (len) queue_byte(plain_byte());
                queue_byte(end_byte());
                made += len + 2;
            end else begin
                nf = $urandom_range(1, 4);
                for (f = 0; f < nf; f++) begin
                    len = $urandom_range(0, 5);
                    repeat (len) queue_byte(plain_byte());
                    queue_byte(f < nf - 1 ? unit_byte() : end_byte());
                    made += len + 1;
                end
            end
        end
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    initial begin
        tk_cfg = '{unit_sep_a: 9'd32, unit_sep_b: 9'd9, record_sep: 9'd10,
                   group_sep: 9'd256, file_sep: 9'd12, comment_char: 9'd35,
                   empty_field_en: 1'b0, empty_record_en: 1'b0};
        tk_mode     = dtt_pkg::MODE_START;
        tk_row      = '0;
        tk_col      = '0;
        tk_row_data = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults: fields, empty record and field, comments, clears, byte extremes
        push_text("a b\tc\n");
        push_text("\n ");
        push_text("#z \n");
        push_text("x#\f");
        queue_byte(8'h00);
        queue_byte(8'hFF);
        push_text("\n\f");
        push_text("d #e\n");
        drain();
        queue_text(30);
        drain();

        // empty fields and records allowed, comment byte at zero
        program_regs(9'h02C, 9'h03B, 9'h00A, 9'h01E, 9'h01C, 9'h000, 9'd1, 9'd1);
        queue_text(30);
        drain();

        // one byte is both unit and record separator; flags take bit 0 only
        program_regs(9'h0FF, 9'h1FF, 9'h0FF, 9'h00D, 9'h100, 9'h023, 9'h002, 9'h1FF);
        queue_text(30);
        drain();

        // drive the field index into saturation, no idling on either side
        program_regs(9'h009, 9'h020, 9'h00A, 9'h100, 9'h00C, 9'h023, 9'd1, 9'd0);
        no_idle = 1'b1;
        repeat (1025) queue_byte(8'h09);
        push_text("ab\tc\n");
        drain();
        no_idle = 1'b0;
        queue_text(20);
        drain();

        // every byte register disabled
        program_regs(9'h100, 9'h1FF, 9'h100, 9'h1FF, 9'h100, 9'h1FF, 9'd0, 9'd0);
        queue_text(15);
        drain();

        program_regs(9'h000, 9'h0FF, 9'h00A, 9'h000, 9'h0FF, 9'h0FF, 9'd1, 9'd0);
        queue_text(20);
        drain();

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
